/* sv/rdq_pkg.sv */
// Shared types and constants for the ring deque.
`default_nettype none

package rdq_pkg;

    // Word and count widths fixed by the item format
    localparam int WORD_W      = 16;
    localparam int CPW         = 9;
    localparam int MODE_W      = 4;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;
    localparam int CNT_MAX     = (1 << CPW) - 1;

    // Operation selector carried on the input tuser
    typedef enum logic [MODE_W-1:0] {
        M_PUSH_HEAD = 4'd0,
        M_PUSH_TAIL = 4'd1,
        M_POP_HEAD  = 4'd2,
        M_POP_TAIL  = 4'd3,
        M_GET_FRONT = 4'd4,
        M_GET_BACK  = 4'd5,
        M_DROP_HEAD = 4'd6,
        M_DROP_TAIL = 4'd7,
        M_CLEAR     = 4'd8,
        M_FILL      = 4'd9
    } t_mode;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // input beat taken, single-cycle part of the op
        logic cfg_we;     // capacity write
        logic rd_done;    // memory read data is ready for the output
        logic fill_step;  // write one zero word during fill
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_read;  // current beat reads the store
        logic need_fill;  // current beat is a fill with free slots
        logic fill_last;  // last zero word of a fill
        logic out_free;   // output register free by the next edge
    } t_stat;

endpackage

`default_nettype wire

/* sv/rdq_ctrl.sv */
// Sequencer for the ring deque: idle, memory read and fill walk.
`default_nettype none

module rdq_ctrl
    import rdq_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_s_valid,
    input  wire   i_cfg_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_s_ready,
    output logic  o_cfg_ready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_FILL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_idle;

    // A capacity write offered while idle wins over an input beat
    assign w_idle      = (r_state == S_IDLE);
    assign o_s_ready   = w_idle && i_stat.out_free && !i_cfg_valid;
    assign o_cfg_ready = w_idle;

    // Commands to the datapath
    always_comb begin
        o_cmd.accept    = i_s_valid && o_s_ready;
        o_cmd.cfg_we    = i_cfg_valid && w_idle;
        o_cmd.rd_done   = (r_state == S_READ);
        o_cmd.fill_step = (r_state == S_FILL);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.accept && i_stat.need_read) begin
                    n_state = S_READ;
                end else if (o_cmd.accept && i_stat.need_fill) begin
                    n_state = S_FILL;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            S_FILL: begin
                if (i_stat.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* sv/rdq_dp.sv */
// Ring deque datapath: positions, fill count, word store and output register.
`default_nettype none

module rdq_dp
    import rdq_pkg::*;
#(
    parameter int STORE_DEPTH = 256
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  wire  [MODE_W-1:0] i_mode,
    input  wire  [WORD_W-1:0] i_data,
    input  wire  [CPW-1:0]    i_arg,
    input  wire  [CPW-1:0]    i_cfg_data,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic [WORD_W-1:0] o_data,
    output logic [CPW-1:0]    o_done,
    output logic              o_ok
);

    localparam int AW      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int XW      = (AW > CPW) ? AW : CPW;
    localparam int CAP_MAX = (STORE_DEPTH < CNT_MAX) ? STORE_DEPTH : CNT_MAX;
    localparam int CAP_RST = (STORE_DEPTH < 256) ? STORE_DEPTH : 256;
    localparam logic [CPW-1:0] CAP_MAX_V = CPW'(CAP_MAX);
    localparam logic [CPW-1:0] CAP_RST_V = CPW'(CAP_RST);

    // Ring state
    logic [CPW-1:0] r_cap, r_head, r_tail, r_fill;
    logic [CPW-1:0] n_head, n_tail, n_fill;

    // Fill walk
    logic [CPW-1:0] r_fill_pos, r_fill_left, r_fill_total;
    logic [CPW:0]   w_fpos_p1;
    logic [CPW-1:0] w_fpos_inc;

    // Store
    logic [WORD_W-1:0] r_mem [STORE_DEPTH];
    logic [WORD_W-1:0] r_rd_data;
    logic              r_pend_pop;

    // Output register
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_data;
    logic [CPW-1:0]    r_out_done;
    logic              r_out_ok;

    t_mode          w_mode;
    logic           w_not_full, w_not_empty, w_in_rng;
    logic [CPW:0]   w_head_p1, w_tail_p1;
    logic [CPW-1:0] w_head_inc, w_head_dec, w_tail_inc, w_tail_dec;
    logic [CPW:0]   w_front_sum, w_back_sum, w_dh_sum, w_dt_sum;
    logic [CPW-1:0] w_front_pos, w_back_pos, w_dh_pos, w_dt_pos;
    logic [CPW-1:0] w_amt, w_free, w_cap_sat;

    // Per-beat decode results
    logic              w_we, w_re, w_need_read, w_need_fill, w_pop;
    logic [CPW-1:0]    w_waddr9, w_raddr9;
    logic [WORD_W-1:0] w_imm_data;
    logic [CPW-1:0]    w_imm_done;
    logic              w_imm_ok;

    logic              w_mem_we;
    logic [CPW-1:0]    w_mem_waddr9;
    logic [WORD_W-1:0] w_mem_wdata;
    logic [XW-1:0]     w_waddr_x, w_raddr_x;
    logic              w_load_imm, w_load_rd, w_load_fill;

    assign w_mode      = t_mode'(i_mode);
    assign w_not_full  = (r_fill < r_cap);
    assign w_not_empty = (r_fill != '0);
    assign w_in_rng    = (i_arg < r_fill);
    assign w_free      = r_cap - r_fill;
    assign w_amt       = w_in_rng ? i_arg : r_fill;

    // Single-step moves around the ring
    assign w_head_p1  = (CPW+1)'(r_head) + (CPW+1)'(1);
    assign w_tail_p1  = (CPW+1)'(r_tail) + (CPW+1)'(1);
    assign w_head_inc = (w_head_p1 == (CPW+1)'(r_cap)) ? '0 : w_head_p1[CPW-1:0];
    assign w_tail_inc = (w_tail_p1 == (CPW+1)'(r_cap)) ? '0 : w_tail_p1[CPW-1:0];
    assign w_head_dec = (r_head == '0) ? (r_cap - CPW'(1)) : (r_head - CPW'(1));
    assign w_tail_dec = (r_tail == '0) ? (r_cap - CPW'(1)) : (r_tail - CPW'(1));

    // Offset positions: every sum stays below twice the capacity
    assign w_front_sum = (CPW+1)'(r_head) + (CPW+1)'(i_arg);
    assign w_back_sum  = (CPW+1)'(r_tail) + (CPW+1)'(r_cap) - (CPW+1)'(1)
                       - (CPW+1)'(i_arg);
    assign w_dh_sum    = (CPW+1)'(r_head) + (CPW+1)'(w_amt);
    assign w_dt_sum    = (CPW+1)'(r_tail) + (CPW+1)'(r_cap) - (CPW+1)'(w_amt);

    assign w_front_pos = (w_front_sum >= (CPW+1)'(r_cap))
                       ? CPW'(w_front_sum - (CPW+1)'(r_cap)) : CPW'(w_front_sum);
    assign w_back_pos  = (w_back_sum >= (CPW+1)'(r_cap))
                       ? CPW'(w_back_sum - (CPW+1)'(r_cap)) : CPW'(w_back_sum);
    assign w_dh_pos    = (w_dh_sum >= (CPW+1)'(r_cap))
                       ? CPW'(w_dh_sum - (CPW+1)'(r_cap)) : CPW'(w_dh_sum);
    assign w_dt_pos    = (w_dt_sum >= (CPW+1)'(r_cap))
                       ? CPW'(w_dt_sum - (CPW+1)'(r_cap)) : CPW'(w_dt_sum);

    // Capacity clamp: zero means one, never above the store
    assign w_cap_sat = (i_cfg_data == '0) ? CPW'(1)
                     : ((i_cfg_data > CAP_MAX_V) ? CAP_MAX_V : i_cfg_data);

    // Operation decode
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_waddr9    = r_tail;
        w_raddr9    = r_head;
        w_need_read = 1'b0;
        w_need_fill = 1'b0;
        w_pop       = 1'b0;
        w_imm_data  = '0;
        w_imm_done  = '0;
        w_imm_ok    = 1'b0;
        case (w_mode)
            M_PUSH_HEAD: begin
                if (w_not_full) begin
                    n_head     = w_head_dec;
                    n_fill     = r_fill + CPW'(1);
                    w_we       = 1'b1;
                    w_waddr9   = w_head_dec;
                    w_imm_done = CPW'(1);
                    w_imm_ok   = 1'b1;
                end
            end
            M_PUSH_TAIL: begin
                if (w_not_full) begin
                    n_tail     = w_tail_inc;
                    n_fill     = r_fill + CPW'(1);
                    w_we       = 1'b1;
                    w_waddr9   = r_tail;
                    w_imm_done = CPW'(1);
                    w_imm_ok   = 1'b1;
                end
            end
            M_POP_HEAD: begin
                if (w_not_empty) begin
                    n_head      = w_head_inc;
                    n_fill      = r_fill - CPW'(1);
                    w_re        = 1'b1;
                    w_raddr9    = r_head;
                    w_need_read = 1'b1;
                    w_pop       = 1'b1;
                end
            end
            M_POP_TAIL: begin
                if (w_not_empty) begin
                    n_tail      = w_tail_dec;
                    n_fill      = r_fill - CPW'(1);
                    w_re        = 1'b1;
                    w_raddr9    = w_tail_dec;
                    w_need_read = 1'b1;
                    w_pop       = 1'b1;
                end
            end
            M_GET_FRONT: begin
                if (w_in_rng) begin
                    w_re        = 1'b1;
                    w_raddr9    = w_front_pos;
                    w_need_read = 1'b1;
                end else begin
                    w_imm_data = i_data;
                end
            end
            M_GET_BACK: begin
                if (w_in_rng) begin
                    w_re        = 1'b1;
                    w_raddr9    = w_back_pos;
                    w_need_read = 1'b1;
                end else begin
                    w_imm_data = i_data;
                end
            end
            M_DROP_HEAD: begin
                n_head     = w_dh_pos;
                n_fill     = r_fill - w_amt;
                w_imm_done = w_amt;
                w_imm_ok   = (i_arg <= r_fill);
            end
            M_DROP_TAIL: begin
                n_tail     = w_dt_pos;
                n_fill     = r_fill - w_amt;
                w_imm_done = w_amt;
                w_imm_ok   = (i_arg <= r_fill);
            end
            M_CLEAR: begin
                n_head   = '0;
                n_tail   = '0;
                n_fill   = '0;
                w_imm_ok = 1'b1;
            end
            M_FILL: begin
                // Ring is marked full at once; the zero words follow
                n_tail      = r_head;
                n_fill      = r_cap;
                w_need_fill = (w_free != '0);
                w_imm_ok    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Ring state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= CAP_RST_V;
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else if (i_cmd.cfg_we) begin
            r_cap  <= w_cap_sat;
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else if (i_cmd.accept) begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    // Fill walk: one zero word per cycle from the old tail
    assign w_fpos_p1  = (CPW+1)'(r_fill_pos) + (CPW+1)'(1);
    assign w_fpos_inc = (w_fpos_p1 == (CPW+1)'(r_cap)) ? '0 : w_fpos_p1[CPW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_need_fill) begin
            r_fill_pos   <= r_tail;
            r_fill_left  <= w_free;
            r_fill_total <= w_free;
        end else if (i_cmd.fill_step) begin
            r_fill_pos  <= w_fpos_inc;
            r_fill_left <= r_fill_left - CPW'(1);
        end
    end

    // Word store, one write and one registered read port
    assign w_mem_we     = (i_cmd.accept && w_we) || i_cmd.fill_step;
    assign w_mem_waddr9 = i_cmd.fill_step ? r_fill_pos : w_waddr9;
    assign w_mem_wdata  = i_cmd.fill_step ? '0 : i_data;
    assign w_waddr_x    = XW'(w_mem_waddr9);
    assign w_raddr_x    = XW'(w_raddr9);

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_waddr_x[AW-1:0]] <= w_mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_re) begin
            r_rd_data  <= r_mem[w_raddr_x[AW-1:0]];
            r_pend_pop <= w_pop;
        end
    end

    // Output register
    assign w_load_imm  = i_cmd.accept && !w_need_read && !w_need_fill;
    assign w_load_rd   = i_cmd.rd_done;
    assign w_load_fill = i_cmd.fill_step && (r_fill_left == CPW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_imm || w_load_rd || w_load_fill) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_imm) begin
            r_out_data <= w_imm_data;
            r_out_done <= w_imm_done;
            r_out_ok   <= w_imm_ok;
        end else if (w_load_rd) begin
            r_out_data <= r_rd_data;
            r_out_done <= CPW'(r_pend_pop);
            r_out_ok   <= 1'b1;
        end else if (w_load_fill) begin
            r_out_data <= '0;
            r_out_done <= r_fill_total;
            r_out_ok   <= 1'b1;
        end
    end

    // Status to the controller
    always_comb begin
        o_stat.need_read = w_need_read;
        o_stat.need_fill = w_need_fill;
        o_stat.fill_last = (r_fill_left == CPW'(1));
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_data      = r_out_data;
    assign o_done      = r_out_done;
    assign o_ok        = r_out_ok;

endmodule

`default_nettype wire

/* sv/ring_deque_16bit.sv */
// Top level of the ring deque: stream ports, capacity port and checks.
`default_nettype none

// Double-ended ring of 16-bit words held in a single-port-write, registered-read
// store of STORE_DEPTH words; the ring uses the first capacity slots (write the
// capacity channel while idle, which also empties the ring, reset value 256
// clamped to the store). One result beat per input beat. Push, drop, clear,
// out-of-range gets, pops on an empty ring and unknown modes set their result
// directly; other pops and in-range gets pass through the read state, set by the
// registered read of the word store; a fill with free slots writes one zero word
// per slot in the fill state through the store's one write port. An input beat
// is taken when idle and the output is empty or being emptied, so a result still
// downstream overlaps the next item; an offered capacity write holds input off.
module ring_deque_16bit
    import rdq_pkg::*;
#(
    parameter int STORE_DEPTH = 256
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // Input stream
    input  wire                    i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire  [IN_TDATA_W-1:0]  i_s_axis_tdata,  // data_in[15:0], index_or_amount[24:16]
    input  wire  [MODE_W-1:0]      i_s_axis_tuser,  // mode[3:0]
    // Result stream
    output logic                   o_m_axis_tvalid,
    input  wire                    i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,  // data_out[15:0], done_count[24:16]
    output logic                   o_m_axis_tuser,  // ok[0]
    // Capacity write
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [CPW-1:0]         i_cfg_data       // capacity_in_use[8:0]
);

    t_cmd              w_cmd;
    t_stat             w_stat;
    logic [WORD_W-1:0] w_data_out;
    logic [CPW-1:0]    w_done_out;

    rdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (i_s_axis_tvalid),
        .i_cfg_valid (i_cfg_valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_s_ready   (o_s_axis_tready),
        .o_cfg_ready (o_cfg_ready)
    );

    rdq_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_mode      (i_s_axis_tuser),
        .i_data      (i_s_axis_tdata[WORD_W-1:0]),
        .i_arg       (i_s_axis_tdata[WORD_W+CPW-1:WORD_W]),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_data      (w_data_out),
        .o_done      (w_done_out),
        .o_ok        (o_m_axis_tuser)
    );

    // Pack the result beat, zero padding above
    assign o_m_axis_tdata = OUT_TDATA_W'({w_done_out, w_data_out});

    // A read item hands its word to the output on the very next cycle
    a_read_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.accept && w_stat.need_read) |=> w_cmd.rd_done)
        else $error("memory read result not loaded after read item");

    // Input is only taken when the output register can take its result
    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("input ready while result register blocked");

    // A new result appears only after an item finished
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |->
            ($past(w_cmd.accept) || $past(w_cmd.rd_done) || $past(w_cmd.fill_step)))
        else $error("result beat without a finished item");

endmodule

`default_nettype wire
